@@ design/gdfs_pkg.sv @@
// Package for the grid depth-first path finder.
// Holds the command, status, direction and register codes and the shared structs.
// No dependencies.
`default_nettype none

package gdfs_pkg;

    // Width that holds a clamped grid dimension up to 256.
    localparam int DIM_W = 9;

    // Commands carried by an input item.
    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_RUN    = 2'd1;
    localparam logic [1:0] CMD_READ_V = 2'd2;
    localparam logic [1:0] CMD_READ_P = 2'd3;

    // Status codes of a result item.
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_UNREACH = 2'd1;
    localparam logic [1:0] STAT_RANGE   = 2'd2;

    // Neighbor directions in visiting order.
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_ROWS      = 3'd0;
    localparam logic [2:0] REG_COLS      = 3'd1;
    localparam logic [2:0] REG_START_ROW = 3'd2;
    localparam logic [2:0] REG_START_COL = 3'd3;
    localparam logic [2:0] REG_GOAL_ROW  = 3'd4;
    localparam logic [2:0] REG_GOAL_COL  = 3'd5;

    typedef struct packed {
        logic [6:0] grid_rows;
        logic [6:0] grid_cols;
        logic [5:0] start_row;
        logic [5:0] start_col;
        logic [5:0] goal_row;
        logic [5:0] goal_col;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [5:0]  cell_row;
        logic [5:0]  cell_col;
        logic        cell_open;
        logic [11:0] entry_index;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [12:0] visited_count;
        logic [11:0] path_moves;
        logic [5:0]  out_row;
        logic [5:0]  out_col;
    } rsp_t;

endpackage : gdfs_pkg

`default_nettype wire

@@ design/gdfs_nbr.sv @@
// Shared neighbor unit: steps the current cell one place in a direction
// and checks that the result lies inside the grid. Uses gdfs_pkg.
`default_nettype none

module gdfs_nbr
    import gdfs_pkg::*;
#(
    parameter int RW = 6,
    parameter int CW = 6
) (
    input  wire logic [RW-1:0]    cur_row,
    input  wire logic [CW-1:0]    cur_col,
    input  wire logic [1:0]       dir,
    input  wire logic [DIM_W-1:0] rows,
    input  wire logic [DIM_W-1:0] cols,
    output logic      [RW-1:0]    nbr_row,
    output logic      [CW-1:0]    nbr_col,
    output logic                  in_grid
);

    // One step in the chosen direction with its bounds check.
    always_comb begin
        nbr_row = cur_row;
        nbr_col = cur_col;
        in_grid = 1'b0;
        case (dir)
            DIR_UP: begin
                nbr_row = cur_row - RW'(1);
                in_grid = (cur_row != '0);
            end
            DIR_LEFT: begin
                nbr_col = cur_col - CW'(1);
                in_grid = (cur_col != '0);
            end
            DIR_RIGHT: begin
                nbr_col = cur_col + CW'(1);
                in_grid = ((DIM_W'(cur_col) + DIM_W'(1)) < cols);
            end
            DIR_DOWN: begin
                nbr_row = cur_row + RW'(1);
                in_grid = ((DIM_W'(cur_row) + DIM_W'(1)) < rows);
            end
            default: in_grid = 1'b0;
        endcase
    end

endmodule : gdfs_nbr

`default_nettype wire

@@ design/gdfs_core.sv @@
// Search sequencer with the grid, mark, stack and list memories.
// Depends on gdfs_pkg and the neighbor unit gdfs_nbr.
`default_nettype none

module gdfs_core
    import gdfs_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic start,
    input  wire req_t req,
    input  wire cfg_t cfg,
    output logic      done,
    output rsp_t      rsp
);

    localparam int RW     = $clog2(MAX_ROWS);
    localparam int CW     = $clog2(MAX_COLS);
    localparam int IW     = RW + CW;
    localparam int NCELLS = MAX_ROWS * MAX_COLS;
    localparam int DEPTH  = 2 ** IW;
    localparam int CNT_W  = $clog2(NCELLS + 1);
    localparam int SW     = IW + CNT_W;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_RDA   = 13'b0000000000010,
        S_RDB   = 13'b0000000000100,
        S_CLR   = 13'b0000000001000,
        S_INIT  = 13'b0000000010000,
        S_TEST  = 13'b0000000100000,
        S_NADDR = 13'b0000001000000,
        S_NCHK  = 13'b0000010000000,
        S_EXP   = 13'b0000100000000,
        S_POP   = 13'b0001000000000,
        S_GOAL  = 13'b0010000000000,
        S_DONE  = 13'b0100000000000,
        S_WAIT  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    req_t             req_reg, req_next;
    logic [DIM_W-1:0] rows_reg, rows_next, cols_reg, cols_next;
    logic [RW-1:0]    cur_row_reg, cur_row_next;
    logic [CW-1:0]    cur_col_reg, cur_col_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] top_reg, top_next;
    logic [CNT_W-1:0] vis_total_reg, vis_total_next;
    logic [CNT_W-1:0] path_total_reg, path_total_next;
    logic [1:0]       dir_reg, dir_next;
    logic [IW-1:0]    clr_addr_reg, clr_addr_next;
    logic [1:0]       status_reg, status_next;
    logic [5:0]       orow_reg, orow_next, ocol_reg, ocol_next;

    // Memories and their registered read data.
    logic              open_mem [DEPTH];
    logic              mark_mem [DEPTH];
    logic [SW-1:0]     stack_mem [DEPTH];
    logic [IW-1:0]     vis_mem [DEPTH];
    logic [IW-1:0]     path_mem [DEPTH];
    logic              open_rd_reg, mark_rd_reg;
    logic [SW-1:0]     stack_rd_reg;
    logic [IW-1:0]     vis_rd_reg, path_rd_reg;

    logic              open_we, mark_we, mark_wd, stack_we, vis_we, path_we;
    logic [IW-1:0]     open_wa, mark_wa, stack_wa, vis_wa, path_wa;
    logic [IW-1:0]     vis_wd, path_wd;
    logic [SW-1:0]     stack_wd;
    logic [IW-1:0]     list_ra, stack_ra;

    logic [RW-1:0]     nbr_row;
    logic [CW-1:0]     nbr_col;
    logic              in_grid;
    logic [IW-1:0]     nbr_idx, cur_idx;
    logic              at_goal;
    logic [CNT_W-1:0]  list_total;
    logic [IW-1:0]     list_data;

    gdfs_nbr #(
        .RW(RW),
        .CW(CW)
    ) u_nbr (
        .cur_row (cur_row_reg),
        .cur_col (cur_col_reg),
        .dir     (dir_reg),
        .rows    (rows_reg),
        .cols    (cols_reg),
        .nbr_row (nbr_row),
        .nbr_col (nbr_col),
        .in_grid (in_grid)
    );

    assign nbr_idx  = {nbr_row, nbr_col};
    assign cur_idx  = {cur_row_reg, cur_col_reg};
    assign at_goal  = (DIM_W'(cur_row_reg) == DIM_W'(cfg.goal_row)) &&
                      (DIM_W'(cur_col_reg) == DIM_W'(cfg.goal_col));
    assign list_ra  = IW'(req_reg.entry_index);
    assign stack_ra = IW'(top_reg - CNT_W'(1));
    assign list_total = (req_reg.command == CMD_READ_V) ? vis_total_reg : path_total_reg;
    assign list_data  = (req_reg.command == CMD_READ_V) ? vis_rd_reg : path_rd_reg;

    // Memory write and read ports.
    always_ff @(posedge aclk) begin
        if (open_we) begin
            open_mem[open_wa] <= req_reg.cell_open;
        end
        open_rd_reg <= open_mem[nbr_idx];
    end

    always_ff @(posedge aclk) begin
        if (mark_we) begin
            mark_mem[mark_wa] <= mark_wd;
        end
        mark_rd_reg <= mark_mem[nbr_idx];
    end

    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[stack_wa] <= stack_wd;
        end
        stack_rd_reg <= stack_mem[stack_ra];
    end

    always_ff @(posedge aclk) begin
        if (vis_we) begin
            vis_mem[vis_wa] <= vis_wd;
        end
        vis_rd_reg <= vis_mem[list_ra];
    end

    always_ff @(posedge aclk) begin
        if (path_we) begin
            path_mem[path_wa] <= path_wd;
        end
        path_rd_reg <= path_mem[list_ra];
    end

    // Sequencer.
    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        rows_next       = rows_reg;
        cols_next       = cols_reg;
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        pos_next        = pos_reg;
        top_next        = top_reg;
        vis_total_next  = vis_total_reg;
        path_total_next = path_total_reg;
        dir_next        = dir_reg;
        clr_addr_next   = clr_addr_reg;
        status_next     = status_reg;
        orow_next       = orow_reg;
        ocol_next       = ocol_reg;
        open_we  = 1'b0;
        open_wa  = {RW'(req_reg.cell_row), CW'(req_reg.cell_col)};
        mark_we  = 1'b0;
        mark_wa  = nbr_idx;
        mark_wd  = 1'b1;
        stack_we = 1'b0;
        stack_wa = IW'(top_reg);
        stack_wd = {nbr_idx, pos_reg + CNT_W'(1)};
        vis_we   = 1'b0;
        vis_wa   = IW'(vis_total_reg);
        vis_wd   = cur_idx;
        path_we  = 1'b0;
        path_wa  = IW'(pos_reg);
        path_wd  = cur_idx;
        done     = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    req_next    = req;
                    status_next = STAT_OK;
                    orow_next   = '0;
                    ocol_next   = '0;
                    case (req.command)
                        CMD_WRITE: state_next = S_WAIT;
                        CMD_RUN: begin
                            if (req.command == CMD_RUN) begin
                                rows_next = (cfg.grid_rows == '0) ? DIM_W'(1) :
                                    ((DIM_W'(cfg.grid_rows) > DIM_W'(MAX_ROWS)) ?
                                    DIM_W'(MAX_ROWS) : DIM_W'(cfg.grid_rows));
                                cols_next = (cfg.grid_cols == '0) ? DIM_W'(1) :
                                    ((DIM_W'(cfg.grid_cols) > DIM_W'(MAX_COLS)) ?
                                    DIM_W'(MAX_COLS) : DIM_W'(cfg.grid_cols));
                            end
                            clr_addr_next = '0;
                            state_next    = S_CLR;
                        end
                        default: state_next = S_RDA;
                    endcase
                end
            end

            // Cell write, if the cell lies in range, lands here in the cycle after the item was taken.
            S_WAIT: begin
                if ((DIM_W'(req_reg.cell_row) < DIM_W'(MAX_ROWS)) &&
                    (DIM_W'(req_reg.cell_col) < DIM_W'(MAX_COLS))) begin
                    open_we = 1'b1;
                    mark_we = 1'b0;
                end
                state_next = S_DONE;
            end

            // List read address is presented; data is registered.
            S_RDA: state_next = S_RDB;

            S_RDB: begin
                if ((32'(req_reg.entry_index) < 32'(list_total)) &&
                    (32'(req_reg.entry_index) < NCELLS)) begin
                    orow_next = 6'(list_data[IW-1:CW]);
                    ocol_next = 6'(list_data[CW-1:0]);
                end else begin
                    status_next = STAT_RANGE;
                end
                state_next = S_DONE;
            end

            // Clear all marks, one entry a cycle.
            S_CLR: begin
                mark_we = 1'b1;
                mark_wa = clr_addr_reg;
                mark_wd = 1'b0;
                clr_addr_next = clr_addr_reg + IW'(1);
                if (clr_addr_reg == IW'(DEPTH - 1)) begin
                    state_next = S_INIT;
                end
            end

            S_INIT: begin
                vis_total_next  = '0;
                path_total_next = '0;
                top_next        = '0;
                if ((DIM_W'(cfg.start_row) >= rows_reg) ||
                    (DIM_W'(cfg.start_col) >= cols_reg)) begin
                    status_next = STAT_UNREACH;
                    state_next  = S_DONE;
                end else begin
                    mark_we      = 1'b1;
                    mark_wa      = {RW'(cfg.start_row), CW'(cfg.start_col)};
                    stack_we     = 1'b1;
                    stack_wa     = '0;
                    stack_wd     = {RW'(cfg.start_row), CW'(cfg.start_col), CNT_W'(0)};
                    top_next     = CNT_W'(1);
                    cur_row_next = RW'(cfg.start_row);
                    cur_col_next = CW'(cfg.start_col);
                    pos_next     = '0;
                    state_next   = S_TEST;
                end
            end

            // Goal check, then pop the current cell.
            S_TEST: begin
                if (at_goal) begin
                    state_next = S_GOAL;
                end else begin
                    if (top_reg != '0) begin
                        top_next = top_reg - CNT_W'(1);
                    end
                    dir_next   = DIR_UP;
                    state_next = S_NADDR;
                end
            end

            // Neighbor address goes to the grid and mark memories.
            S_NADDR: begin
                if (in_grid) begin
                    state_next = S_NCHK;
                end else if (dir_reg == DIR_DOWN) begin
                    state_next = S_EXP;
                end else begin
                    dir_next = dir_reg + 2'd1;
                end
            end

            // Push an open, unmarked neighbor with its depth tag.
            S_NCHK: begin
                if (open_rd_reg && !mark_rd_reg) begin
                    stack_we = 1'b1;
                    mark_we  = 1'b1;
                    top_next = top_reg + CNT_W'(1);
                end
                if (dir_reg == DIR_DOWN) begin
                    state_next = S_EXP;
                end else begin
                    dir_next   = dir_reg + 2'd1;
                    state_next = S_NADDR;
                end
            end

            // Record the expanded cell; stack top is read for the next one.
            S_EXP: begin
                if (32'(vis_total_reg) < NCELLS) begin
                    vis_we         = 1'b1;
                    vis_total_next = vis_total_reg + CNT_W'(1);
                end
                path_we = (32'(pos_reg) < NCELLS);
                if (top_reg == '0) begin
                    path_total_next = '0;
                    status_next     = STAT_UNREACH;
                    state_next      = S_DONE;
                end else begin
                    state_next = S_POP;
                end
            end

            S_POP: begin
                cur_row_next = stack_rd_reg[SW-1:CW+CNT_W];
                cur_col_next = stack_rd_reg[CW+CNT_W-1:CNT_W];
                pos_next     = stack_rd_reg[CNT_W-1:0];
                state_next   = S_TEST;
            end

            S_GOAL: begin
                if (32'(vis_total_reg) < NCELLS) begin
                    vis_we         = 1'b1;
                    vis_total_next = vis_total_reg + CNT_W'(1);
                end
                if (32'(pos_reg) < NCELLS) begin
                    path_we         = 1'b1;
                    path_total_next = pos_reg + CNT_W'(1);
                end
                status_next = STAT_OK;
                state_next  = S_DONE;
            end

            S_DONE: begin
                done       = 1'b1;
                state_next = S_IDLE;
            end

            default: state_next = S_IDLE;
        endcase
    end

    // Result fields shown with the done pulse.
    always_comb begin
        rsp.status        = status_reg;
        rsp.visited_count = 13'(vis_total_reg);
        rsp.path_moves    = (path_total_reg != '0) ?
                            12'(path_total_reg - CNT_W'(1)) : 12'd0;
        rsp.out_row       = orow_reg;
        rsp.out_col       = ocol_reg;
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            vis_total_reg  <= '0;
            path_total_reg <= '0;
            top_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            vis_total_reg  <= vis_total_next;
            path_total_reg <= path_total_next;
            top_reg        <= top_next;
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        rows_reg     <= rows_next;
        cols_reg     <= cols_next;
        cur_row_reg  <= cur_row_next;
        cur_col_reg  <= cur_col_next;
        pos_reg      <= pos_next;
        dir_reg      <= dir_next;
        clr_addr_reg <= clr_addr_next;
        status_reg   <= status_next;
        orow_reg     <= orow_next;
        ocol_reg     <= ocol_next;
    end

endmodule : gdfs_core

`default_nettype wire

@@ design/grid_dfs_path_finder.sv @@
// A cell write passes S_WAIT, a list read S_RDA and S_RDB. A run clears all 2**(RW+CW)
// mark entries, then each expanded cell visits S_TEST, S_EXP and S_POP, with S_NADDR
// per neighbor and S_NCHK per in-grid neighbor, plus setup, goal and output states.
// One item at a time, set by the shared neighbor unit and the one-read, one-write
// memories; the next item is taken the cycle after the result item leaves.
// Reset (aresetn, synchronous, active low) clears control state, totals, stack top and config registers.
`default_nettype none

module grid_dfs_path_finder
    import gdfs_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // command, cell_row, cell_col, cell_open, entry_index from bit 0 up
    input  wire logic [31:0] s_tdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // status, visited_count, path_moves, out_row, out_col from bit 0 up
    output logic [39:0]      m_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cfg_t  cfg_reg;
    req_t  req;
    rsp_t  rsp;
    logic  done;
    logic  busy_reg;
    logic  m_valid_reg;
    rsp_t  m_data_reg;
    logic  s_fire;

    assign req.command     = s_tdata[1:0];
    assign req.cell_row    = s_tdata[7:2];
    assign req.cell_col    = s_tdata[13:8];
    assign req.cell_open   = s_tdata[14];
    assign req.entry_index = s_tdata[26:15];

    assign s_tready = !busy_reg && !m_valid_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign pready   = 1'b1;

    gdfs_core #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_fire),
        .req     (req),
        .cfg     (cfg_reg),
        .done    (done),
        .rsp     (rsp)
    );

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.grid_rows <= 7'd1;
            cfg_reg.grid_cols <= 7'd1;
            cfg_reg.start_row <= '0;
            cfg_reg.start_col <= '0;
            cfg_reg.goal_row  <= '0;
            cfg_reg.goal_col  <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
                REG_ROWS:      cfg_reg.grid_rows <= pwdata[6:0];
                REG_COLS:      cfg_reg.grid_cols <= pwdata[6:0];
                REG_START_ROW: cfg_reg.start_row <= pwdata[5:0];
                REG_START_COL: cfg_reg.start_col <= pwdata[5:0];
                REG_GOAL_ROW:  cfg_reg.goal_row  <= pwdata[5:0];
                REG_GOAL_COL:  cfg_reg.goal_col  <= pwdata[5:0];
                default:       cfg_reg.grid_rows <= cfg_reg.grid_rows;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (paddr[4:2])
            REG_ROWS:      prdata = 32'(cfg_reg.grid_rows);
            REG_COLS:      prdata = 32'(cfg_reg.grid_cols);
            REG_START_ROW: prdata = 32'(cfg_reg.start_row);
            REG_START_COL: prdata = 32'(cfg_reg.start_col);
            REG_GOAL_ROW:  prdata = 32'(cfg_reg.goal_row);
            REG_GOAL_COL:  prdata = 32'(cfg_reg.goal_col);
            default:       prdata = 32'd0;
        endcase
    end

    // Busy flag and output item register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                busy_reg <= 1'b1;
            end else if (done) begin
                busy_reg <= 1'b0;
            end
            if (done) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            m_data_reg <= rsp;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_data_reg.out_col, m_data_reg.out_row,
                       m_data_reg.path_moves, m_data_reg.visited_count,
                       m_data_reg.status};

endmodule : grid_dfs_path_finder

`default_nettype wire

@@ tb/grid_dfs_path_finder_test.sv @@
// Self-checking testbench for the grid depth-first path finder.
// Needs gdfs_pkg and grid_dfs_path_finder. A built-in predictor of the search
// supplies the expected result of every item.
`timescale 1ns / 1ps

module grid_dfs_path_finder_test;
    import gdfs_pkg::*;

    localparam int MAP_DIM = 64;
    localparam int MAP_CELLS = MAP_DIM * MAP_DIM;

    logic        aclk;
    logic        aresetn;
    logic [31:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    grid_dfs_path_finder i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor state: register copies, grid, stack and both lists.
    logic [6:0] cur_rows, cur_cols;
    logic [5:0] cur_start_row, cur_start_col, cur_goal_row, cur_goal_col;
    bit         open_cells[MAP_CELLS];
    bit         marked_cells[MAP_CELLS];
    bit         written_cells[MAP_CELLS];
    int         dfs_stack_cell[MAP_CELLS + 1];
    int         dfs_stack_depth[MAP_CELLS + 1];
    int         dfs_top;
    int         visited_cells[MAP_CELLS];
    int         path_cells[MAP_CELLS];
    int         visited_total;
    int         path_total;

    rsp_t       pending_results[$];
    bit         failed;
    bit         send_idle_on;
    bit         recv_idle_on;
    int         recv_hold;

    // Clock and watchdog.
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #40ms;
        $display("tb: failure");
        $finish;
    end

    function automatic int clamp_dim(logic [6:0] v);
        if (v == 0) return 1;
        if (v > MAP_DIM) return MAP_DIM;
        return int'(v);
    endfunction

    // Depth-first search over the loaded grid; returns the run status.
    function automatic logic [1:0] search_grid();
        int rows, cols, cr, cc, gr, gc, pos, idx, nr, nc, ni, d;
        rows = clamp_dim(cur_rows);
        cols = clamp_dim(cur_cols);
        gr = int'(cur_goal_row);
        gc = int'(cur_goal_col);
        pos = 0;
        foreach (marked_cells[i]) marked_cells[i] = 1'b0;
        dfs_top = 0;
        visited_total = 0;
        path_total = 0;
        if (int'(cur_start_row) >= rows || int'(cur_start_col) >= cols) return STAT_UNREACH;
        cr = int'(cur_start_row);
        cc = int'(cur_start_col);
        idx = cr * MAP_DIM + cc;
        marked_cells[idx] = 1'b1;
        dfs_stack_cell[0] = idx;
        dfs_stack_depth[0] = 0;
        dfs_top = 1;
        while (cr != gr || cc != gc) begin
            if (dfs_top > 0) dfs_top--;
            for (d = 0; d < 4; d++) begin
                nr = cr;
                nc = cc;
                case (d[1:0])
                    DIR_UP:    nr = cr - 1;
                    DIR_LEFT:  nc = cc - 1;
                    DIR_RIGHT: nc = cc + 1;
                    DIR_DOWN:  nr = cr + 1;
                    default:   nr = cr;
                endcase
                if (nr < 0 || nr >= rows || nc < 0 || nc >= cols) continue;
                ni = nr * MAP_DIM + nc;
                if (open_cells[ni] && !marked_cells[ni] && dfs_top <= MAP_CELLS) begin
                    dfs_stack_cell[dfs_top] = ni;
                    dfs_stack_depth[dfs_top] = pos + 1;
                    dfs_top++;
                    marked_cells[ni] = 1'b1;
                end
            end
            idx = cr * MAP_DIM + cc;
            if (visited_total < MAP_CELLS) visited_cells[visited_total++] = idx;
            if (pos < MAP_CELLS) path_cells[pos] = idx;
            if (dfs_top == 0) begin
                path_total = 0;
                return STAT_UNREACH;
            end
            pos = dfs_stack_depth[dfs_top - 1];
            idx = dfs_stack_cell[dfs_top - 1];
            cr = idx / MAP_DIM;
            cc = idx % MAP_DIM;
        end
        idx = gr * MAP_DIM + gc;
        if (visited_total < MAP_CELLS) visited_cells[visited_total++] = idx;
        if (pos < MAP_CELLS) begin
            path_cells[pos] = idx;
            path_total = pos + 1;
        end
        return STAT_OK;
    endfunction

    // Expected result of one accepted item.
    function automatic rsp_t predict_result(req_t r);
        rsp_t res;
        int   total, v;
        res = '0;
        case (r.command)
            CMD_WRITE: begin
                open_cells[r.cell_row * MAP_DIM + r.cell_col] = r.cell_open;
                written_cells[r.cell_row * MAP_DIM + r.cell_col] = 1'b1;
            end
            CMD_RUN: res.status = search_grid();
            default: begin
                total = (r.command == CMD_READ_V) ? visited_total : path_total;
                if (int'(r.entry_index) < total) begin
                    v = (r.command == CMD_READ_V) ? visited_cells[r.entry_index]
                                                  : path_cells[r.entry_index];
                    res.out_row = 6'(v / MAP_DIM);
                    res.out_col = 6'(v % MAP_DIM);
                end else begin
                    res.status = STAT_RANGE;
                end
            end
        endcase
        res.visited_count = 13'(visited_total);
        res.path_moves = 12'((path_total != 0) ? path_total - 1 : 0);
        return res;
    endfunction

    // Offers one item, possibly after a random gap, and waits for acceptance.
    task automatic send_item(req_t r);
        if (send_idle_on && $urandom_range(0, 99) < 19) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, r.entry_index, r.cell_open, r.cell_col, r.cell_row, r.command};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_result(r));
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    task automatic send_cmd(logic [1:0] cmd, int row, int col, bit opn, int index);
        req_t r;
        r.command = cmd;
        r.cell_row = 6'(row);
        r.cell_col = 6'(col);
        r.cell_open = opn;
        r.entry_index = 12'(index);
        send_item(r);
    endtask

    // Waits until every expected result has come back.
    task automatic drain();
        stop_sending();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Register write over the configuration port; the block is idle here.
    task automatic write_reg(logic [2:0] index, int value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            REG_ROWS:      cur_rows = 7'(value);
            REG_COLS:      cur_cols = 7'(value);
            REG_START_ROW: cur_start_row = 6'(value);
            REG_START_COL: cur_start_col = 6'(value);
            REG_GOAL_ROW:  cur_goal_row = 6'(value);
            default:       cur_goal_col = 6'(value);
        endcase
    endtask

    task automatic set_grid(int rows, int cols, int sr, int sc, int gr, int gc);
        drain();
        write_reg(REG_ROWS, rows);
        write_reg(REG_COLS, cols);
        write_reg(REG_START_ROW, sr);
        write_reg(REG_START_COL, sc);
        write_reg(REG_GOAL_ROW, gr);
        write_reg(REG_GOAL_COL, gc);
    endtask

    // Loads every in-grid cell not yet written, or all of them with rewrite, open with the given odds.
    task automatic fill_grid(int open_pct, bit rewrite);
        int rows, cols;
        rows = clamp_dim(cur_rows);
        cols = clamp_dim(cur_cols);
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < cols; c++)
                if (rewrite || !written_cells[r * MAP_DIM + c])
                    send_cmd(CMD_WRITE, r, c, $urandom_range(0, 99) < open_pct,
                             $urandom_range(0, 4095));
    endtask

    // Run followed by reads of random lists; the last asks for entry path_total, past the path list's end.
    task automatic run_and_read(int reads);
        send_cmd(CMD_RUN, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1),
                 $urandom_range(0, 4095));
        for (int i = 0; i < reads; i++)
            send_cmd($urandom_range(0, 1) ? CMD_READ_V : CMD_READ_P, 0, 0, 0,
                     (i == reads - 1) ? path_total : $urandom_range(0, visited_total));
    endtask

    // Result checker and receiver stalls.
    initial begin
        rsp_t got, want;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = rsp_t'({m_tdata[1:0], m_tdata[14:2], m_tdata[26:15],
                              m_tdata[32:27], m_tdata[38:33]});
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result item %h", $time, m_tdata);
                    failed = 1'b1;
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status)
                        $display("%0t: status expected %0d got %0d", $time,
                                 want.status, got.status);
                    if (got.visited_count !== want.visited_count)
                        $display("%0t: visited_count expected %0d got %0d", $time,
                                 want.visited_count, got.visited_count);
                    if (got.path_moves !== want.path_moves)
                        $display("%0t: path_moves expected %0d got %0d", $time,
                                 want.path_moves, got.path_moves);
                    if (got.out_row !== want.out_row)
                        $display("%0t: out_row expected %0d got %0d", $time,
                                 want.out_row, got.out_row);
                    if (got.out_col !== want.out_col)
                        $display("%0t: out_col expected %0d got %0d", $time,
                                 want.out_col, got.out_col);
                    if (got !== want) failed = 1'b1;
                end
            end
            if (recv_hold > 0) begin
                recv_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(recv_idle_on && $urandom_range(0, 99) < 19);
            end
        end
    end

    // Corner cases: clamped sizes, single cell, walls, outside start and goal.
    task automatic test_directed();
        set_grid(0, 0, 0, 0, 0, 0);
        send_cmd(CMD_WRITE, 63, 63, 1, 4095);
        send_cmd(CMD_WRITE, 0, 0, 0, 0);
        run_and_read(1);
        send_cmd(CMD_READ_V, 0, 0, 0, 4095);
        send_cmd(CMD_READ_P, 0, 0, 0, 1);
        // Start on the last clamped row, so the row below must count as outside.
        set_grid(127, 1, 63, 0, 61, 0);
        for (int r = 61; r < 64; r++)
            send_cmd(CMD_WRITE, r, 0, 1, 0);
        run_and_read(3);
        send_cmd(CMD_READ_P, 0, 0, 0, 63);
        // Same on the last clamped column.
        set_grid(1, 127, 0, 63, 0, 61);
        for (int c = 61; c < 64; c++)
            send_cmd(CMD_WRITE, 0, c, 1, 0);
        run_and_read(3);
        set_grid(5, 5, 2, 2, 0, 4);
        fill_grid(100, 1'b1);
        send_cmd(CMD_WRITE, 2, 2, 0, 0);
        run_and_read(2);
        send_cmd(CMD_WRITE, 0, 3, 0, 0);
        send_cmd(CMD_WRITE, 1, 4, 0, 0);
        run_and_read(2);
        set_grid(5, 5, 4, 4, 40, 1);
        run_and_read(2);
        set_grid(5, 5, 63, 0, 1, 1);
        run_and_read(2);
    endtask

    // Random grids and commands, mostly small so runs stay short.
    task automatic test_random(int phases);
        int rows, cols;
        for (int p = 0; p < phases; p++) begin
            rows = $urandom_range(1, 6);
            cols = $urandom_range(1, 6);
            set_grid(rows, cols, $urandom_range(0, 9) ? $urandom_range(0, rows - 1) : 63,
                     $urandom_range(0, cols - 1),
                     $urandom_range(0, 7) ? $urandom_range(0, rows - 1) : $urandom_range(0, 63),
                     $urandom_range(0, cols - 1));
            send_idle_on = (p % 3 != 1);
            recv_idle_on = (p % 3 != 1);
            fill_grid(75, 1'b0);
            for (int i = 0; i < 2; i++)
                send_cmd(CMD_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 1), $urandom_range(0, 4095));
            run_and_read(4);
            send_cmd(2'($urandom_range(2, 3)), $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 1), $urandom_range(0, 4095));
        end
    endtask

    // Receiver holds off while items keep coming, then the sender waits it out.
    task automatic test_backpressure();
        set_grid(4, 4, 0, 0, 3, 3);
        fill_grid(80, 1'b0);
        drain();
        recv_hold = 300;
        for (int i = 0; i < 10; i++)
            send_cmd(2'($urandom_range(2, 3)), 0, 0, 0, $urandom_range(0, 8));
        drain();
        run_and_read(5);
    endtask

    initial begin
        failed = 1'b0;
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        recv_hold = 0;
        cur_rows = 1;
        cur_cols = 1;
        cur_start_row = 0;
        cur_start_col = 0;
        cur_goal_row = 0;
        cur_goal_col = 0;
        visited_total = 0;
        path_total = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(3);
        test_backpressure();

        drain();
        repeat (50) @(posedge aclk);
        if (!failed) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
